/* src/fjb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjb_pkg: shared types and constants of the fragment jitter buffer
// Request and response payloads, status codes and the slot completion helpers.
// ----------------------------------------------------------------------------
package fjb_pkg;

  localparam int SLOTS     = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int MAX_FRAG  = 16;
  localparam int FRAG_W    = 5;
  localparam int FIDX_W    = 4;
  localparam int SEQ_W     = 31;
  localparam int CNT_W     = 6;
  localparam int LAT_W     = 5;
  localparam int MASK_W    = MAX_FRAG + 1;

  localparam logic [LAT_W-1:0]         LAT_DEFAULT    = LAT_W'(SLOTS / 2);
  localparam logic [LAT_W-1:0]         BACKLOG_MARGIN = LAT_W'(4);
  localparam logic signed [CNT_W-1:0]  CNT_MIN        = CNT_W'(-(2 * SLOTS));
  localparam logic signed [CNT_W-1:0]  CNT_OVER       = CNT_W'(SLOTS);
  localparam logic [SEQ_W:0]           JUMP_LIMIT     = (SEQ_W + 1)'(SLOTS);

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_PULL = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_FRAG_RECEIVED = 3'd1,
    ST_FRAG_DROPPED  = 3'd2,
    ST_PKT_DROPPED   = 3'd3,
    ST_OVERWROTE     = 3'd4,
    ST_NEED_DATA     = 3'd5,
    ST_ERROR         = 3'd6
  } status_e;

  typedef struct packed {
    logic              action;
    logic [SEQ_W-1:0]  seq_number;
    logic [FIDX_W-1:0] fragment_index;
    logic [FRAG_W-1:0] fragment_total;
  } fjb_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic              packet_ready;
    logic [FRAG_W-1:0] max_fragments_seen;
  } fjb_rsp_t;

  // Write side of the sequence store.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [SEQ_W-1:0]  data;
  } fjb_seq_wr_t;

  function automatic logic [MAX_FRAG-1:0] frag_mask(input logic [FRAG_W-1:0] cnt);
    logic [MASK_W-1:0] one_hot;
    one_hot   = MASK_W'(1) << cnt;
    frag_mask = MAX_FRAG'(one_hot - MASK_W'(1));
  endfunction

  function automatic logic slot_complete(input logic [FRAG_W-1:0]   cnt,
                                         input logic [MAX_FRAG-1:0] map);
    slot_complete = (cnt != '0) && (map == frag_mask(cnt));
  endfunction

endpackage

/* src/fjb_seq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjb_seq_ram: sequence number store
// One write and one registered read port; a same-cycle write to the read
// address is passed through so the reader always sees the newest value.
// ----------------------------------------------------------------------------
module fjb_seq_ram
  import fjb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output logic [SEQ_W-1:0]  rd_data_o,
  input  fjb_seq_wr_t       wr_i
);

  logic [SEQ_W-1:0] mem_q [SLOTS];
  logic [SEQ_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.we && (wr_i.addr == rd_addr_i)) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/fjb_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjb_engine: slot state and push/pull decision logic
// Holds per-slot fragment tracking and the buffer counters, and works out the
// response and the next state for one request combinationally.
// ----------------------------------------------------------------------------
module fjb_engine
  import fjb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              exec_i,
  input  fjb_req_t          req_i,
  input  logic [SEQ_W-1:0]  slot_seq_i,
  input  logic [LAT_W-1:0]  latency_i,
  output fjb_rsp_t          rsp_o,
  output fjb_seq_wr_t       seq_wr_o
);

  logic                     held_q [SLOTS];
  logic                     held_d [SLOTS];
  logic [FRAG_W-1:0]        cnt_q  [SLOTS];
  logic [FRAG_W-1:0]        cnt_d  [SLOTS];
  logic [MAX_FRAG-1:0]      map_q  [SLOTS];
  logic [MAX_FRAG-1:0]      map_d  [SLOTS];
  logic signed [CNT_W-1:0]  cc_q, cc_d;
  logic                     refill_q, refill_d;
  logic [SLOT_W-1:0]        rs_q, rs_d;
  logic [SEQ_W-1:0]         prev_q, prev_d;
  logic                     pv_q, pv_d;
  logic [FRAG_W-1:0]        largest_q, largest_d;
  logic [FRAG_W-1:0]        cur_q, cur_d;

  logic [SEQ_W-1:0]         seq;
  logic [FRAG_W-1:0]        total;
  logic [SLOT_W-1:0]        s;
  logic                     bad_total;
  logic                     resync;
  logic                     h1;
  logic [FRAG_W-1:0]        cnt1;
  logic [MAX_FRAG-1:0]      map1;
  logic signed [CNT_W-1:0]  cc1, cc2, cc3;
  logic                     cmp1, step_a, step_b, step_c, step_d, held2;
  logic [MAX_FRAG-1:0]      map_base, map_new, frag_bit;
  logic                     frag_ok, cmp_new;
  logic [LAT_W-1:0]         lat;
  logic signed [CNT_W-1:0]  lat_s;
  logic signed [CNT_W:0]    backlog_lim;
  logic                     backlog;
  logic [SLOT_W-1:0]        nx;
  logic                     cmp_next;
  logic signed [CNT_W-1:0]  cc_pull;
  logic [2:0]               status;

  assign seq       = req_i.seq_number;
  assign total     = req_i.fragment_total;
  assign s         = seq[SLOT_W-1:0];
  assign bad_total = (total == '0) || (total > FRAG_W'(MAX_FRAG));

  // A jump of more than one buffer's worth of sequence numbers restarts it.
  always_comb begin
    if (seq > prev_q) begin
      resync = pv_q && (({1'b0, seq} - {1'b0, prev_q}) > JUMP_LIMIT);
    end else begin
      resync = pv_q && (({1'b0, prev_q} - {1'b0, seq}) > JUMP_LIMIT);
    end
  end

  assign h1   = resync ? 1'b0 : held_q[s];
  assign cnt1 = resync ? cur_q : cnt_q[s];
  assign map1 = resync ? '0 : map_q[s];
  assign cc1  = resync ? '0 : cc_q;

  assign cmp1   = slot_complete(cnt1, map1);
  assign step_a = (cnt1 != total);
  assign step_b = !step_a && cmp1;
  assign held2  = h1 && !step_a && !step_b;
  assign step_c = held2 && (seq > slot_seq_i);
  assign step_d = held2 && (seq < slot_seq_i);

  assign cc2 = (cmp1 && (cc1 != CNT_MIN)) ? cc1 - CNT_W'(1) : cc1;
  assign cc3 = cc2 + CNT_W'(1);

  assign map_base = (step_a || step_b || step_c) ? '0 : map1;
  assign frag_bit = MAX_FRAG'(1) << req_i.fragment_index;
  assign frag_ok  = (FRAG_W'(req_i.fragment_index) < total) && ((map_base & frag_bit) == '0);
  assign map_new  = frag_ok ? (map_base | frag_bit) : map_base;
  assign cmp_new  = slot_complete(total, map_new);

  assign lat         = (latency_i == '0) ? LAT_DEFAULT : latency_i;
  assign lat_s       = $signed({1'b0, lat});
  assign backlog_lim = $signed({2'b00, lat} + {2'b00, BACKLOG_MARGIN});
  assign backlog     = $signed({cc_q[CNT_W-1], cc_q}) > backlog_lim;

  assign nx       = rs_q + SLOT_W'(1);
  assign cmp_next = slot_complete(cnt_q[nx], map_q[nx]);
  assign cc_pull  = (cc_q != CNT_MIN) ? cc_q - CNT_W'(1) : cc_q;

  always_comb begin
    held_d    = held_q;
    cnt_d     = cnt_q;
    map_d     = map_q;
    cc_d      = cc_q;
    refill_d  = refill_q;
    rs_d      = rs_q;
    prev_d    = prev_q;
    pv_d      = pv_q;
    largest_d = largest_q;
    cur_d     = cur_q;
    status    = ST_OK;
    rsp_o     = '0;
    seq_wr_o  = '0;

    if (exec_i) begin
      if (req_i.action == ACT_PUSH) begin
        if (bad_total) begin
          status = ST_ERROR;
        end else begin
          prev_d = seq;
          pv_d   = 1'b1;
          if (resync) begin
            for (int i = 0; i < SLOTS; i++) begin
              held_d[i] = 1'b0;
              map_d[i]  = '0;
              cnt_d[i]  = cur_q;
            end
            refill_d = 1'b1;
            rs_d     = s - SLOT_W'(1);
          end
          cc_d = (step_a && cmp1) || step_b ? cc2 : cc1;
          if (step_a || step_b || step_c) begin
            cur_d = total;
          end
          if (step_a && (total > largest_q)) begin
            largest_d = total;
          end
          if (step_d) begin
            // An older packet than the one held: the fragment is discarded.
            status = ST_PKT_DROPPED;
          end else begin
            held_d[s]     = 1'b1;
            cnt_d[s]      = total;
            map_d[s]      = map_new;
            seq_wr_o.we   = 1'b1;
            seq_wr_o.addr = s;
            seq_wr_o.data = seq;
            if (step_c) begin
              status = ST_OVERWROTE;
            end else if (step_b) begin
              status = ST_PKT_DROPPED;
            end
            if (!frag_ok) begin
              status = ST_FRAG_DROPPED;
            end
            if (cmp_new) begin
              cc_d = cc3;
              if (cc3 >= lat_s) begin
                refill_d = 1'b0;
              end
              if (cc3 > CNT_OVER) begin
                status = ST_ERROR;
              end
            end else if (status == ST_OK) begin
              status = ST_FRAG_RECEIVED;
            end
          end
        end
      end else begin
        status = ST_NEED_DATA;
        if (!refill_q) begin
          if (cmp_next || backlog) begin
            held_d[rs_q] = 1'b0;
            map_d[rs_q]  = '0;
            cur_d        = cnt_q[rs_q];
            rs_d         = nx;
          end
          if (cmp_next) begin
            cc_d = cc_pull;
            if (cc_pull == '0) begin
              refill_d = 1'b1;
            end
            rsp_o.slot_index   = nx;
            rsp_o.packet_ready = 1'b1;
            status             = ST_OK;
          end
          if (cc_d[CNT_W-1]) begin
            status = ST_ERROR;
          end
        end
      end
    end

    rsp_o.status             = status;
    rsp_o.max_fragments_seen = largest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        held_q[i] <= 1'b0;
        cnt_q[i]  <= FRAG_W'(1);
        map_q[i]  <= '0;
      end
      cc_q      <= '0;
      refill_q  <= 1'b1;
      rs_q      <= SLOT_W'(SLOTS - 1);
      pv_q      <= 1'b0;
      largest_q <= FRAG_W'(1);
      cur_q     <= FRAG_W'(1);
    end else begin
      held_q    <= held_d;
      cnt_q     <= cnt_d;
      map_q     <= map_d;
      cc_q      <= cc_d;
      refill_q  <= refill_d;
      rs_q      <= rs_d;
      pv_q      <= pv_d;
      largest_q <= largest_d;
      cur_q     <= cur_d;
    end
  end

  // Only meaningful while the valid flag is set, so no reset.
  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

endmodule

/* src/fragment_jitter_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_jitter_buffer: jitter buffer with fragment reassembly tracking
// Tracks which fragments of each packet have arrived in a sixteen-slot ring
// and releases complete packets in sequence order once enough are buffered.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   -------   ---------  -------------------------  -------------------------
//   in        input      in_valid_i / in_stall_o    in_data_i  (fjb_req_t)
//   out       output     out_valid_o / out_stall_i  out_data_o (fjb_rsp_t)
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (latency)
//
// Each request gives exactly one response after it is accepted: it is held
// in the request register (while the slot's sequence number is read
// from its store), then a single pass of decision logic into the response
// register. A new request can be taken every cycle unless a stalled response holds the pipeline.
// Reset is asynchronous and active low; all slots come out empty at once.
// A stalled response holds the response register, which in turn holds the
// request register and raises in_stall_o; no request is ever lost.
//
module fragment_jitter_buffer
  import fjb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fjb_req_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fjb_rsp_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LAT_W-1:0] cfg_data_i
);

  logic             in_valid_q, in_valid_d;
  fjb_req_t         req_q;
  logic             out_valid_q, out_valid_d;
  fjb_rsp_t         rsp_q;
  fjb_rsp_t         rsp;
  logic [LAT_W-1:0] latency_q;
  logic             accept;
  logic             exec;
  logic [SEQ_W-1:0] slot_seq;
  fjb_seq_wr_t      seq_wr;

  // The request in the register proceeds whenever the response register is
  // empty or is being emptied in this cycle.
  assign exec        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !exec;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_valid_d  = accept || (in_valid_q && !exec);
  assign out_valid_d = exec || (out_valid_q && out_stall_i);

  // The configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      latency_q   <= LAT_W'(8);
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        latency_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (exec) begin
      rsp_q <= rsp;
    end
  end

  // The sequence store is read as the request is captured, so its data lines
  // up with the request register in the next cycle.
  fjb_seq_ram u_seq_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (in_data_i.seq_number[SLOT_W-1:0]),
    .rd_data_o (slot_seq),
    .wr_i      (seq_wr)
  );

  fjb_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exec_i     (exec),
    .req_i      (req_q),
    .slot_seq_i (slot_seq),
    .latency_i  (latency_q),
    .rsp_o      (rsp),
    .seq_wr_o   (seq_wr)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

`ifndef SYNTHESIS
  // A request that moves on always leaves a response behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> out_valid_o)
    else $error("response missing after a request was processed");

  // A held request stays in the request register unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !exec) |=> (in_valid_q && $stable(req_q)))
    else $error("held request was lost or changed");

  // A released packet is reported only with a good or error status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.packet_ready) |->
      (out_data_o.status == ST_OK || out_data_o.status == ST_ERROR))
    else $error("packet released with an unexpected status");
`endif

endmodule

/* tb/fragment_jitter_buffer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_jitter_buffer_tb: self-checking bench for the fragment jitter buffer
// Drives push and pull requests with random idle gaps and output stalls. A
// scoreboard keeps its own copy of the slot ring and predicts every response.
// ----------------------------------------------------------------------------
module fragment_jitter_buffer_tb
  import fjb_pkg::*;
();

  // Scoreboard: a cycle-free copy of the buffer state. Each accepted request
  // is applied to the copy at once and the response it must produce is
  // queued. Responses leave the block in request order, so the oldest queue
  // entry is always the one to compare against.
  class fjb_scoreboard;
    fjb_rsp_t            expected_q[$];
    logic [LAT_W-1:0]    latency_reg;
    logic [SEQ_W-1:0]    slot_seq[SLOTS];
    bit                  slot_held[SLOTS];
    logic [FRAG_W-1:0]   slot_total[SLOTS];
    logic [MAX_FRAG-1:0] slot_map[SLOTS];
    int                  complete_cnt;
    bit                  refilling;
    logic [SLOT_W-1:0]   read_slot;
    logic [SEQ_W-1:0]    last_seq;
    bit                  last_seq_valid;
    logic [FRAG_W-1:0]   widest_total;
    logic [FRAG_W-1:0]   clear_total;
    int                  errors;

    function new();
      int i;
      latency_reg    = LAT_DEFAULT;
      clear_total    = FRAG_W'(1);
      widest_total   = FRAG_W'(1);
      complete_cnt   = 0;
      refilling      = 1'b1;
      read_slot      = SLOT_W'(SLOTS - 1);
      last_seq       = '0;
      last_seq_valid = 1'b0;
      errors         = 0;
      for (i = 0; i < SLOTS; i++) begin
        slot_seq[i] = '0;
        clear_slot(i);
      end
    endfunction

    function void clear_slot(int s);
      slot_held[s]  = 1'b0;
      slot_map[s]   = '0;
      slot_total[s] = clear_total;
    endfunction

    function bit is_complete(int s);
      logic [MAX_FRAG-1:0] full;
      int i;
      full = '0;
      for (i = 0; i < slot_total[s]; i++) full[i] = 1'b1;
      return (slot_total[s] != 0) && (slot_map[s] == full);
    endfunction

    // The count floors at minus twice the ring size.
    function void count_down();
      if (complete_cnt > -2 * SLOTS) complete_cnt--;
    endfunction

    function void note_request(fjb_req_t req);
      fjb_rsp_t rsp;
      status_e  st;
      int       s, nxt, lat, i;
      longint   seq_now, seq_old, seq_gap;
      bit       late;
      rsp = '0;
      lat = (latency_reg == 0) ? SLOTS / 2 : int'(latency_reg);
      if (req.action == ACT_PULL) begin
        st = ST_NEED_DATA;
        if (!refilling) begin
          nxt = (int'(read_slot) + 1) % SLOTS;
          if (is_complete(nxt)) begin
            clear_total = slot_total[read_slot];
            clear_slot(read_slot);
            read_slot = SLOT_W'(nxt);
            count_down();
            if (complete_cnt == 0) refilling = 1'b1;
            rsp.slot_index   = read_slot;
            rsp.packet_ready = 1'b1;
            st = ST_OK;
          end else if (complete_cnt > lat + 4) begin
            // Backed up behind a hole: step over it.
            clear_total = slot_total[read_slot];
            clear_slot(read_slot);
            read_slot = SLOT_W'(nxt);
          end
          if (complete_cnt < 0) st = ST_ERROR;
        end
      end else if (req.fragment_total == 0 || req.fragment_total > MAX_FRAG) begin
        st = ST_ERROR;
      end else begin
        st = ST_OK;
        if (last_seq_valid) begin
          seq_now = longint'(req.seq_number);
          seq_old = longint'(last_seq);
          seq_gap = seq_now - seq_old;
          if (seq_gap < 0) seq_gap = -seq_gap;
          if (seq_gap > SLOTS) begin
            for (i = 0; i < SLOTS; i++) clear_slot(i);
            complete_cnt = 0;
            refilling    = 1'b1;
            read_slot    = req.seq_number[SLOT_W-1:0] - SLOT_W'(1);
          end
        end
        last_seq       = req.seq_number;
        last_seq_valid = 1'b1;
        s = int'(req.seq_number[SLOT_W-1:0]);
        if (slot_total[s] != req.fragment_total) begin
          if (is_complete(s)) count_down();
          if (req.fragment_total > widest_total) widest_total = req.fragment_total;
          clear_total = req.fragment_total;
          clear_slot(s);
        end
        if (is_complete(s)) begin
          clear_total = req.fragment_total;
          clear_slot(s);
          count_down();
          st = ST_PKT_DROPPED;
        end
        if (slot_held[s] && req.seq_number > slot_seq[s]) begin
          clear_total = req.fragment_total;
          clear_slot(s);
          st = ST_OVERWROTE;
        end
        late = slot_held[s] && (req.seq_number < slot_seq[s]);
        if (late) begin
          st = ST_PKT_DROPPED;
        end else begin
          slot_seq[s]  = req.seq_number;
          slot_held[s] = 1'b1;
          if (req.fragment_index < req.fragment_total && !slot_map[s][req.fragment_index]) begin
            slot_map[s][req.fragment_index] = 1'b1;
          end else begin
            st = ST_FRAG_DROPPED;
          end
          if (is_complete(s)) begin
            complete_cnt++;
            if (complete_cnt >= lat) refilling = 1'b0;
            if (complete_cnt > SLOTS) st = ST_ERROR;
          end else if (st == ST_OK) begin
            st = ST_FRAG_RECEIVED;
          end
        end
      end
      rsp.status             = st;
      rsp.max_fragments_seen = widest_total;
      expected_q.push_back(rsp);
    endfunction

    function void check_response(fjb_rsp_t got);
      fjb_rsp_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: response with none pending: status %0d slot %0d ready %0d max %0d",
                   $realtime, got.status, got.slot_index, got.packet_ready,
                   got.max_fragments_seen);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.packet_ready !== want.packet_ready ||
          got.max_fragments_seen !== want.max_fragments_seen) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: expected status %0d slot %0d ready %0d max %0d, got %0d %0d %0d %0d",
                   $realtime, want.status, want.slot_index, want.packet_ready,
                   want.max_fragments_seen, got.status, got.slot_index,
                   got.packet_ready, got.max_fragments_seen);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  fjb_req_t         in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  fjb_rsp_t         out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [LAT_W-1:0] cfg_data_i;

  fjb_scoreboard sb = new();

  // Shared between the request driver and the response-side staller.
  // quiet turns off all idling on both sides; hold_cycles asks the staller
  // for one long hold-off.
  bit               quiet;
  int               hold_cycles;
  int               requests_sent;
  logic [SEQ_W-1:0] pkt_seq;

  fragment_jitter_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Both handshakes are observed here, at the rising edge. Inputs only move
  // at the falling edge, so the values seen are the ones the block latches.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_response(out_data_o);
    end
  end

  // Idle the request channel for a random number of cycles. While valid is
  // low the payload is scrambled so the block cannot lean on stale data.
  task automatic idle_gap();
    int          n, roll;
    logic [63:0] junk;
    roll = $urandom_range(99);
    if (quiet || roll < 60) n = 0;
    else if (roll < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 30);
    if (n > 0) begin
      junk = {$urandom, $urandom};
      in_valid_i <= 1'b0;
      in_data_i  <= junk[$bits(fjb_req_t)-1:0];
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests never drop valid.
  task automatic send_request(input fjb_req_t req);
    idle_gap();
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    requests_sent++;
  endtask

  task automatic send_push(input logic [SEQ_W-1:0] seq, input int fidx, input int total);
    fjb_req_t req;
    req.action         = ACT_PUSH;
    req.seq_number     = seq;
    req.fragment_index = fidx[FIDX_W-1:0];
    req.fragment_total = total[FRAG_W-1:0];
    send_request(req);
  endtask

  task automatic send_pull();
    fjb_req_t req;
    req.action         = ACT_PULL;
    req.seq_number     = SEQ_W'({$urandom});
    req.fragment_index = FIDX_W'($urandom);
    req.fragment_total = FRAG_W'($urandom);
    send_request(req);
  endtask

  // Wait for every outstanding response, then idle further so the
  // pipeline is certainly empty before the register is touched.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_latency(input int value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= LAT_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.latency_reg = LAT_W'(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic. Most of it is whole packets with their fragments in a
  // shuffled order, since only complete packets fill the buffer far enough
  // for pulls to release anything. The rest is pulls, loose fragments
  // (late, out of range, bad counts) and sequence jumps.
  task automatic random_traffic(input int count);
    int order[MAX_FRAG + 1];
    int stop_at, roll, total, n, i, j, tmp;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        repeat ($urandom_range(1, 3)) send_pull();
      end else if (roll < 85) begin
        total = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(1, MAX_FRAG);
        for (i = 0; i < total; i++) order[i] = i;
        for (i = total - 1; i > 0; i--) begin
          j        = $urandom_range(i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        n = total;
        if ($urandom_range(9) == 0) begin
          order[n] = $urandom_range(total - 1);
          n++;
        end
        for (i = 0; i < n; i++) send_push(pkt_seq, order[i], total);
        // Occasionally leave a hole so the pull side has something to skip.
        roll = $urandom_range(9);
        if (roll == 0) pkt_seq = pkt_seq + SEQ_W'(2);
        else if (roll == 1) pkt_seq = pkt_seq + SEQ_W'(3);
        else pkt_seq = pkt_seq + SEQ_W'(1);
      end else if (roll < 95) begin
        total = ($urandom_range(1)) ? $urandom_range(31) : $urandom_range(1, 4);
        if ($urandom_range(1)) begin
          send_push(pkt_seq - SEQ_W'($urandom_range(1, 12)), $urandom_range(15), total);
        end else begin
          send_push(pkt_seq + SEQ_W'($urandom_range(4)), $urandom_range(15), total);
        end
      end else begin
        roll = $urandom_range(9);
        if (roll < 7) pkt_seq = SEQ_W'($urandom);
        else if (roll < 9) pkt_seq = {SEQ_W{1'b1}} - SEQ_W'($urandom_range(20));
        else pkt_seq = SEQ_W'($urandom_range(20));
      end
    end
  endtask

  // Response-side staller. Each span is one level held for a random number
  // of cycles; a long hold-off request from the driver takes priority.
  initial begin : response_staller
    int span, roll;
    bit level;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      roll = $urandom_range(99);
      if (hold_cycles > 0) begin
        span        = hold_cycles;
        hold_cycles = 0;
        level       = 1'b1;
      end else if (quiet) begin
        span  = 1;
        level = 1'b0;
      end else if (roll < 55) begin
        span  = $urandom_range(1, 20);
        level = 1'b0;
      end else if (roll < 90) begin
        span  = $urandom_range(1, 3);
        level = 1'b1;
      end else begin
        span  = $urandom_range(5, 30);
        level = 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= level;
      repeat (span - 1) @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int lat_plan[6];
    int ph;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    hold_cycles   = 0;
    requests_sent = 0;
    pkt_seq       = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, reset latency. A pull before anything is buffered,
    // illegal fragment counts, a fragment beyond its packet, duplicates,
    // overwrite by a newer packet, a late packet, the widest packet and
    // two sequence jumps (one of them across the wrap of the counter).
    send_pull();
    send_push(31'd5, 0, 0);
    send_push(31'd5, 0, MAX_FRAG + 1);
    send_push(31'd5, 0, 31);
    send_push(31'd0, 0, 1);
    send_push(31'd0, 0, 1);
    send_push(31'd1, 5, 3);
    send_push(31'd1, 1, 3);
    send_push(31'd1, 1, 3);
    send_push(31'd1, 0, 3);
    send_push(31'd1, 2, 3);
    send_push(31'd2, 0, 2);
    send_push(31'd18, 1, 2);
    send_push(31'd2, 1, 2);
    send_push(31'd3, 15, MAX_FRAG);
    send_push({SEQ_W{1'b1}}, 0, 1);
    send_push(31'd0, 0, 1);
    drain();

    // Shortest latency: release a packet, then rewrite the released slot
    // with a different count so the completion count goes negative.
    write_latency(1);
    send_push(31'd1, 0, 1);
    send_pull();
    send_push(31'd0, 0, 2);
    send_pull();
    send_pull();
    send_push(31'd2, 0, 1);
    drain();

    lat_plan = '{1, 16, 2, 8, 15, 1};
    lat_plan[5] = $urandom_range(1, 16);
    pkt_seq = SEQ_W'($urandom_range(100, 1000));
    for (ph = 0; ph < 6; ph++) begin
      write_latency(lat_plan[ph]);
      if (ph == 2) begin
        // Back pressure: the receiver holds off for a long stretch while
        // requests keep coming with no gaps, so the input stalls.
        quiet       = 1'b1;
        hold_cycles = 80;
        random_traffic(60);
      end
      quiet = (ph == 3);
      random_traffic(85);
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("fragment_jitter_buffer: match");
    end else begin
      $display("fragment_jitter_buffer: mismatch");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("fragment_jitter_buffer: mismatch");
    $finish;
  end

endmodule
